[hw/rtl/sorted_priority_task_queue_unit_assert.svh]
// Assertion macros for the sorted priority task queue.
// No dependencies; included by the top level only.
`ifndef SORTED_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_TASK_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("spq assertion failed");
`define SPQ_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk_s, rst_s, prop)
`define SPQ_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

[hw/rtl/spq_pkg.sv]
// Shared types and constants of the sorted priority task queue.
// No dependencies; used by spq_cell and the top level.
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 256;
  localparam int TASK_BITS_DEF     = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  localparam int ID_BITS     = 16;
  localparam int PRIO_BITS   = 16;
  localparam int STATUS_BITS = 2;
  localparam int OCC_BITS    = 9;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds a task and its priority.
// Depends on spq_pkg (spq_ctrl_t).
module spq_cell #(
  parameter int TASK_BITS     = spq_pkg::TASK_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  spq_pkg::spq_ctrl_t       ctrl,
  input  logic                     occupied,
  input  logic                     left_gt,
  input  logic [TASK_BITS-1:0]     new_task,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [TASK_BITS-1:0]     left_task,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [TASK_BITS-1:0]     right_task,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic                     gt,
  output logic [TASK_BITS-1:0]     task_q,
  output logic [PRIORITY_BITS-1:0] prio_q
);

  logic [TASK_BITS-1:0]     task_r, task_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // strictly higher stays put; new request goes ahead of equals
  assign gt = occupied && (prio_r > new_prio);

  always_comb begin
    task_nxt = task_r;
    prio_nxt = prio_r;
    if (ctrl.push) begin
      if (!gt) begin
        if (left_gt) begin
          task_nxt = new_task;
          prio_nxt = new_prio;
        end else begin
          task_nxt = left_task;
          prio_nxt = left_prio;
        end
      end
    end else if (ctrl.pop) begin
      task_nxt = right_task;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    prio_r <= prio_nxt;
  end

  assign task_q = task_r;
  assign prio_q = prio_r;

endmodule

[hw/rtl/sorted_priority_task_queue_unit.sv]
// Sorted priority task queue, top level: a chain of spq_cell slots plus
// count and result registers. Depends on spq_pkg, spq_cell and the assert header.
//
// Use:
//   in_* channel takes one request: in_operation push (0) or pop (1), with
//   in_task_id and in_task_priority for a push. out_* channel returns one
//   result per request: popped task/priority/valid, status and occupancy.
//   Slot 0 of the chain is the head. A push compares its priority against
//   every slot at once; slots with a strictly higher priority hold, the
//   first other slot takes the new task and the rest move one place down.
//   A pop moves every slot one place up.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one request per cycle while the result channel does not stall.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; slot contents are not cleared and are never read while unused.
//   When out_ready is low with a result held, in_ready drops until the
//   result is taken.
`include "sorted_priority_task_queue_unit_assert.svh"
module sorted_priority_task_queue_unit #(
  parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS     = spq_pkg::TASK_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [spq_pkg::ID_BITS-1:0]      in_task_id,
  input  logic [spq_pkg::PRIO_BITS-1:0]    in_task_priority,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spq_pkg::ID_BITS-1:0]      out_popped_task,
  output logic [spq_pkg::PRIO_BITS-1:0]    out_popped_priority,
  output logic                             out_popped_valid,
  output logic [spq_pkg::STATUS_BITS-1:0]  out_status,
  output logic [spq_pkg::OCC_BITS-1:0]     out_occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IB = spq_pkg::ID_BITS;
  localparam int PB = spq_pkg::PRIO_BITS;
  localparam int OB = spq_pkg::OCC_BITS;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [IB-1:0] out_task_r;
  logic [PB-1:0] out_prio_r;
  logic          out_pv_r;
  logic [spq_pkg::STATUS_BITS-1:0] out_status_r, status_nxt;
  logic [OB-1:0] out_occ_r;

  logic in_fire, is_push, full, empty;
  spq_pkg::spq_ctrl_t ctrl;

  logic [TASK_BITS-1:0]     new_task;
  logic [PRIORITY_BITS-1:0] new_prio;

  logic [TASK_BITS-1:0]     c_task [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] c_prio [QUEUE_DEPTH];
  logic                     c_gt   [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_push  = (in_operation == spq_pkg::OP_PUSH);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  assign ctrl.push = in_fire && is_push && !full;
  assign ctrl.pop  = in_fire && !is_push && !empty;

  assign new_task = TASK_BITS'(in_task_id);
  assign new_prio = PRIORITY_BITS'(in_task_priority);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TASK_BITS-1:0]     l_task, r_task;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic                     l_gt;

    if (i == 0) begin : g_head
      assign l_task = new_task;
      assign l_prio = new_prio;
      assign l_gt   = 1'b1;
    end else begin : g_mid
      assign l_task = c_task[i-1];
      assign l_prio = c_prio[i-1];
      assign l_gt   = c_gt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_task = c_task[i];
      assign r_prio = c_prio[i];
    end else begin : g_body
      assign r_task = c_task[i+1];
      assign r_prio = c_prio[i+1];
    end

    spq_cell #(
      .TASK_BITS     (TASK_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count_r),
      .left_gt    (l_gt),
      .new_task   (new_task),
      .new_prio   (new_prio),
      .left_task  (l_task),
      .left_prio  (l_prio),
      .right_task (r_task),
      .right_prio (r_prio),
      .gt         (c_gt[i]),
      .task_q     (c_task[i]),
      .prio_q     (c_prio[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    if (ctrl.push) count_nxt = count_r + CW'(1);
    if (ctrl.pop)  count_nxt = count_r - CW'(1);
    if (in_fire && is_push && full)   status_nxt = spq_pkg::ST_FULL;
    if (in_fire && !is_push && empty) status_nxt = spq_pkg::ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_task_r   <= ctrl.pop ? IB'(c_task[0]) : '0;
      out_prio_r   <= ctrl.pop ? PB'(c_prio[0]) : '0;
      out_pv_r     <= ctrl.pop;
      out_status_r <= status_nxt;
      out_occ_r    <= OB'(count_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_popped_task     = out_task_r;
  assign out_popped_priority = out_prio_r;
  assign out_popped_valid    = out_pv_r;
  assign out_status          = out_status_r;
  assign out_occupancy       = out_occ_r;

  `SPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH))
  `SPQ_ASSERT(a_stall_blocks, clk, rst_n, (out_valid_r && !out_ready) |-> !in_ready)
  `SPQ_ASSERT(a_pop_result, clk, rst_n, ctrl.pop |=> (out_pv_r && (out_status_r == spq_pkg::ST_OK)))
  `SPQ_ASSERT(a_head_sorted, clk, rst_n, (count_r >= CW'(2)) |-> (c_prio[0] >= c_prio[1]))

endmodule
